// ===== design/cdfb_pkg.sv =====
// Shared constants, types and helper functions of the cepstral delta feature builder.
`default_nettype none

package cdfb_pkg;

	localparam int MAX_COEFS      = 16;
	localparam int SHORT_SPAN     = 2;
	localparam int LONG_SPAN      = 4;
	localparam int ACCEL_SPAN     = 1;
	localparam int HISTORY_FRAMES = 13;
	localparam int SAMPLE_WIDTH   = 16;

	localparam int ACC_REACH  = SHORT_SPAN + ACCEL_SPAN;
	localparam int REACH      = (LONG_SPAN > ACC_REACH) ? LONG_SPAN : ACC_REACH;
	localparam int LAG        = 2 * REACH;
	localparam int MIN_FRAMES = 2 * REACH + 1;

	// fixed port widths
	localparam int CFG_W   = 5;
	localparam int FRAME_W = 16;
	localparam int COEF_W  = 16;
	localparam int IDX_W   = 4;
	localparam int SD_W    = 17;
	localparam int LD_W    = 17;
	localparam int AD_W    = 18;

	localparam int POS_W  = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
	localparam int CNT_W  = $clog2(MAX_COEFS + 1);
	localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam int SLOT_W = $clog2(HISTORY_FRAMES);
	localparam int DEPTH  = HISTORY_FRAMES * MAX_COEFS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int OFF_W  = $clog2(2 * REACH + 1) + 1;
	localparam int RING_W = ((SLOT_W > OFF_W) ? SLOT_W : OFF_W) + 2;
	localparam int BACK_W = $clog2(LAG);
	localparam int STEP_W = 3;

	// read steps of one result: two window reads each
	localparam logic [STEP_W-1:0] STEP_SHORT  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_LONG   = 3'd1;
	localparam logic [STEP_W-1:0] STEP_ACC_HI = 3'd2;
	localparam logic [STEP_W-1:0] STEP_ACC_LO = 3'd3;
	localparam logic [STEP_W-1:0] STEP_CEP    = 3'd4;

	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef logic [SLOT_W-1:0]              slot_t;
	typedef logic signed [OFF_W-1:0]        off_t;
	typedef logic [POS_W-1:0]               pos_t;
	typedef logic [ADDR_W-1:0]              addr_t;
	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [FRAME_W-1:0]             frame_t;

	// one read step handed from the sequencer to the delta datapath
	typedef struct packed {
		logic              valid;
		logic [STEP_W-1:0] step;
		frame_t            frame_index;
		pos_t              pos;
		logic              frame_done;
		logic              utt_done;
		logic              too_short;
	} issue_t;

	// ring slot at a signed frame offset from base
	function automatic slot_t ring_add(slot_t base, off_t off);
		logic signed [RING_W-1:0] s;
		s = signed'({{(RING_W - SLOT_W){1'b0}}, base}) + RING_W'(off);
		if (s < 0)
			s = s + RING_W'(HISTORY_FRAMES);
		else if (s >= RING_W'(HISTORY_FRAMES))
			s = s - RING_W'(HISTORY_FRAMES);
		return s[SLOT_W-1:0];
	endfunction

	// centre of a delta of reach x moved in from the utterance ends
	function automatic off_t centre_shift(frame_t t, frame_t e, int x);
		off_t c;
		if (t < FRAME_W'(x))
			c = OFF_W'(x) - OFF_W'(t);
		else if (e < FRAME_W'(x))
			c = OFF_W'(e) - OFF_W'(x);
		else
			c = '0;
		return c;
	endfunction

	function automatic logic [CMP_W-1:0] sat_count(logic [CFG_W-1:0] c);
		logic [CMP_W-1:0] v;
		v = CMP_W'(c);
		if (v == '0)
			v = CMP_W'(1);
		else if (v > CMP_W'(MAX_COEFS))
			v = CMP_W'(MAX_COEFS);
		return v;
	endfunction

	function automatic addr_t slot_addr(slot_t s, pos_t p);
		return ADDR_W'(s) * ADDR_W'(MAX_COEFS) + ADDR_W'(p);
	endfunction

endpackage

`default_nettype wire

// ===== design/cdfb_ram.sv =====
// Generic simple dual-port RAM: one write port, two registered read ports.
`default_nettype none

module cdfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 208
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	// read-first on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

`default_nettype wire

// ===== design/cdfb_decode.sv =====
// Input buffer, frame/flush bookkeeping, window writes and the read-step sequencer.
`default_nettype none

module cdfb_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic signed [cdfb_pkg::COEF_W-1:0] coef_value,
	input  logic                              end_of_utterance,
	input  logic                              cfg_valid,
	input  logic [cdfb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              run,
	output logic                              we,
	output cdfb_pkg::addr_t                   waddr,
	output cdfb_pkg::sample_t                 wdata,
	output cdfb_pkg::addr_t                   raddr_a,
	output cdfb_pkg::addr_t                   raddr_b,
	output cdfb_pkg::issue_t                  issue
);
	import cdfb_pkg::*;

	// input buffer
	logic               buf_valid_q;
	logic               buf_cmd_q;
	sample_t            buf_value_q;
	logic               buf_eou_q;

	logic [CFG_W-1:0]   coef_count_q;
	frame_t             frames_received_q;
	pos_t               coef_pos_q;
	frame_t             frames_emitted_q;
	logic               flushing_q;
	slot_t              write_slot_q;
	logic [BACK_W-1:0]  flush_back_q;

	// item under read
	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	slot_t              tslot_q;
	off_t               cs_q;
	off_t               cl_q;
	off_t               ca_q;
	frame_t             frame_index_q;
	pos_t               pos_q;
	logic               fdone_q;
	logic               udone_q;
	logic               short_q;

	logic [CMP_W-1:0]   cnt;
	logic               last;
	logic               seq_free;
	logic               pop;
	logic               data_ok;
	logic               flush_ok;
	logic               lag_met;
	logic               made;
	slot_t              last_slot;
	frame_t             t_sel;
	frame_t             e_sel;
	frame_t             back_ext;
	slot_t              tslot_sel;
	logic               short_sel;
	off_t               neg_back;
	off_t               off_a;
	off_t               off_b;

	always_comb begin
		cnt       = sat_count(coef_count_q);
		last      = (CMP_W'(coef_pos_q) + 1'b1) >= cnt;
		seq_free  = !busy_q || step_q == STEP_CEP;
		pop       = run && buf_valid_q && seq_free;
		data_ok   = buf_cmd_q == CMD_DATA && !flushing_q;
		flush_ok  = buf_cmd_q == CMD_FLUSH && flushing_q;
		lag_met   = frames_received_q >= FRAME_W'(LAG);
		made      = (data_ok && lag_met) || flush_ok;
		last_slot = ring_add(write_slot_q, OFF_W'(-1));
		back_ext  = FRAME_W'(flush_back_q);
		neg_back  = -OFF_W'({1'b0, flush_back_q});
		if (buf_cmd_q == CMD_DATA) begin
			t_sel     = frames_received_q - FRAME_W'(LAG);
			e_sel     = '1;
			tslot_sel = ring_add(write_slot_q, OFF_W'(-LAG));
			short_sel = 1'b0;
		end else begin
			t_sel     = (frames_received_q > back_ext) ?
			            frames_received_q - 1'b1 - back_ext : '0;
			e_sel     = back_ext;
			tslot_sel = ring_add(last_slot, neg_back);
			short_sel = frames_received_q < FRAME_W'(MIN_FRAMES);
		end
	end

	assign in_stall = buf_valid_q;
	assign we       = pop && data_ok;
	assign waddr    = slot_addr(write_slot_q, coef_pos_q);
	assign wdata    = buf_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q       <= 1'b0;
			coef_count_q      <= CFG_W'(13);
			frames_received_q <= '0;
			coef_pos_q        <= '0;
			frames_emitted_q  <= '0;
			flushing_q        <= 1'b0;
			write_slot_q      <= '0;
			flush_back_q      <= '0;
			busy_q            <= 1'b0;
			step_q            <= STEP_SHORT;
		end else begin
			if (cfg_valid) begin
				coef_count_q <= cfg_data;
			end
			if (in_valid && !buf_valid_q) begin
				buf_valid_q <= 1'b1;
			end else if (pop) begin
				buf_valid_q <= 1'b0;
			end
			if (run) begin
				if (pop && made) begin
					busy_q <= 1'b1;
					step_q <= STEP_SHORT;
				end else if (seq_free) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (pop && data_ok) begin
				if (last) begin
					coef_pos_q <= '0;
					if (frames_received_q != '1)
						frames_received_q <= frames_received_q + 1'b1;
					write_slot_q <= (write_slot_q == SLOT_W'(HISTORY_FRAMES - 1)) ?
					                '0 : write_slot_q + 1'b1;
					if (lag_met)
						frames_emitted_q <= frames_emitted_q + 1'b1;
					if (buf_eou_q) begin
						flushing_q   <= 1'b1;
						// count after this frame is frames_received_q + 1
						flush_back_q <= (frames_received_q >= FRAME_W'(MIN_FRAMES - 1)) ?
						                BACK_W'(LAG - 1) : BACK_W'(frames_received_q);
					end
				end else begin
					coef_pos_q <= coef_pos_q + 1'b1;
				end
			end else if (pop && flush_ok) begin
				if (last) begin
					coef_pos_q <= '0;
					if (flush_back_q == '0) begin
						flushing_q        <= 1'b0;
						frames_received_q <= '0;
						frames_emitted_q  <= '0;
						write_slot_q      <= '0;
					end else begin
						frames_emitted_q <= frames_emitted_q + 1'b1;
						flush_back_q     <= flush_back_q - 1'b1;
					end
				end else begin
					coef_pos_q <= coef_pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !buf_valid_q) begin
			buf_cmd_q   <= command;
			buf_value_q <= SAMPLE_WIDTH'(coef_value);
			buf_eou_q   <= end_of_utterance;
		end
		if (pop && made) begin
			tslot_q       <= tslot_sel;
			cs_q          <= centre_shift(t_sel, e_sel, SHORT_SPAN);
			cl_q          <= centre_shift(t_sel, e_sel, LONG_SPAN);
			ca_q          <= centre_shift(t_sel, e_sel, ACC_REACH);
			frame_index_q <= frames_emitted_q;
			pos_q         <= coef_pos_q;
			fdone_q       <= last;
			udone_q       <= flush_ok && last && flush_back_q == '0;
			short_q       <= short_sel;
		end
	end

	// frame offsets of the two samples read in each step
	always_comb begin
		unique case (step_q)
			STEP_SHORT: begin
				off_a = cs_q + OFF_W'(SHORT_SPAN);
				off_b = cs_q - OFF_W'(SHORT_SPAN);
			end
			STEP_LONG: begin
				off_a = cl_q + OFF_W'(LONG_SPAN);
				off_b = cl_q - OFF_W'(LONG_SPAN);
			end
			STEP_ACC_HI: begin
				off_a = ca_q + OFF_W'(ACCEL_SPAN + SHORT_SPAN);
				off_b = ca_q + OFF_W'(ACCEL_SPAN - SHORT_SPAN);
			end
			STEP_ACC_LO: begin
				off_a = ca_q + OFF_W'(SHORT_SPAN - ACCEL_SPAN);
				off_b = ca_q - OFF_W'(ACCEL_SPAN + SHORT_SPAN);
			end
			default: begin
				off_a = '0;
				off_b = '0;
			end
		endcase
	end

	assign raddr_a = slot_addr(ring_add(tslot_q, off_a), pos_q);
	assign raddr_b = slot_addr(ring_add(tslot_q, off_b), pos_q);

	always_comb begin
		issue.valid       = busy_q;
		issue.step        = step_q;
		issue.frame_index = frame_index_q;
		issue.pos         = pos_q;
		issue.frame_done  = fdone_q;
		issue.utt_done    = udone_q;
		issue.too_short   = short_q;
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q < HISTORY_FRAMES)
		else $error("write slot outside the ring");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && run && step_q != STEP_CEP |=> busy_q && step_q == $past(step_q) + 1'b1)
		else $error("read sequence broke off mid item");

	a_flush_has_frames: assert property (@(posedge clk) disable iff (!arst_n)
		flushing_q |-> frames_received_q != '0)
		else $error("flush with no frames received");

endmodule

`default_nettype wire

// ===== design/cdfb_calc.sv =====
// Delta datapath: collects window reads, forms the deltas and holds the result register.
`default_nettype none

module cdfb_calc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdfb_pkg::issue_t                    issue,
	input  cdfb_pkg::sample_t                   rdata_a,
	input  cdfb_pkg::sample_t                   rdata_b,
	output logic                                run,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cdfb_pkg::FRAME_W-1:0]        frame_index,
	output logic [cdfb_pkg::IDX_W-1:0]          coef_index,
	output logic signed [cdfb_pkg::COEF_W-1:0]  cep_out,
	output logic signed [cdfb_pkg::SD_W-1:0]    short_delta,
	output logic signed [cdfb_pkg::LD_W-1:0]    long_delta,
	output logic signed [cdfb_pkg::AD_W-1:0]    accel_delta,
	output logic                                frame_done,
	output logic                                utterance_done,
	output logic                                too_short
);
	import cdfb_pkg::*;

	issue_t                         info_s1;
	logic signed [SAMPLE_WIDTH:0]   diff;
	logic signed [SAMPLE_WIDTH:0]   sd_q;
	logic signed [SAMPLE_WIDTH:0]   ld_q;
	logic signed [SAMPLE_WIDTH:0]   ad1_q;
	logic signed [SAMPLE_WIDTH+1:0] ad_q;
	logic                           load;

	logic                           out_valid_q;
	logic [FRAME_W-1:0]             frame_index_q;
	logic [IDX_W-1:0]               coef_index_q;
	logic signed [COEF_W-1:0]       cep_out_q;
	logic signed [SD_W-1:0]         short_delta_q;
	logic signed [LD_W-1:0]         long_delta_q;
	logic signed [AD_W-1:0]         accel_delta_q;
	logic                           frame_done_q;
	logic                           utterance_done_q;
	logic                           too_short_q;

	assign diff = {rdata_a[SAMPLE_WIDTH-1], rdata_a} - {rdata_b[SAMPLE_WIDTH-1], rdata_b};
	assign load = info_s1.valid && info_s1.step == STEP_CEP;
	// hold the whole pipe while a finished result cannot be placed
	assign run  = !(load && out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (run) begin
				info_s1 <= issue;
			end
			if (load && run) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run && info_s1.valid) begin
			case (info_s1.step)
				STEP_SHORT:  sd_q  <= diff;
				STEP_LONG:   ld_q  <= diff;
				STEP_ACC_HI: ad1_q <= diff;
				STEP_ACC_LO: ad_q  <= {ad1_q[SAMPLE_WIDTH], ad1_q} - {diff[SAMPLE_WIDTH], diff};
				default: ;
			endcase
		end
		if (load && run) begin
			frame_index_q    <= info_s1.frame_index;
			coef_index_q     <= IDX_W'(info_s1.pos);
			cep_out_q        <= COEF_W'(rdata_a);
			short_delta_q    <= info_s1.too_short ? '0 : SD_W'(sd_q);
			long_delta_q     <= info_s1.too_short ? '0 : LD_W'(ld_q);
			accel_delta_q    <= info_s1.too_short ? '0 : AD_W'(ad_q);
			frame_done_q     <= info_s1.frame_done;
			utterance_done_q <= info_s1.utt_done;
			too_short_q      <= info_s1.too_short;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_index    = frame_index_q;
	assign coef_index     = coef_index_q;
	assign cep_out        = cep_out_q;
	assign short_delta    = short_delta_q;
	assign long_delta     = long_delta_q;
	assign accel_delta    = accel_delta_q;
	assign frame_done     = frame_done_q;
	assign utterance_done = utterance_done_q;
	assign too_short      = too_short_q;

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load && run |=> out_valid)
		else $error("finished result not presented");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_short |->
		short_delta == '0 && long_delta == '0 && accel_delta == '0)
		else $error("short utterance with nonzero delta");

	a_utt_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && utterance_done |-> frame_done)
		else $error("utterance end off a frame boundary");

endmodule

`default_nettype wire

// ===== design/cepstral_delta_feature_builder_top.sv =====
// Top level of the cepstral delta feature builder.
// Coefficients enter one per transaction, frame by frame; each one is written into a
// 13-frame history RAM and, once 8 frames have arrived, the coefficient of the frame
// 8 back comes out with its short, long and double deltas. After the end-of-utterance
// mark, flush transactions drain the last 8 frames (all of a shorter utterance), one
// result each. A result's nine window samples are read from the history RAM two per
// cycle over its two read ports while the pipe is not held. Transactions that yield
// nothing (frames still inside the lag, data during a flush, a flush while idle) read
// no window. One input transaction is buffered while the previous one is being read,
// and a finished result waits in the output register while the next is read. Window
// entries are undefined until written; there is no clearing pass after reset. The
// coefficient count write is always taken and must only happen while the block is idle.
`default_nettype none

module cepstral_delta_feature_builder_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic signed [cdfb_pkg::COEF_W-1:0]  coef_value,
	input  logic                                end_of_utterance,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cdfb_pkg::CFG_W-1:0]          coef_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cdfb_pkg::FRAME_W-1:0]        frame_index,
	output logic [cdfb_pkg::IDX_W-1:0]          coef_index,
	output logic signed [cdfb_pkg::COEF_W-1:0]  cep_out,
	output logic signed [cdfb_pkg::SD_W-1:0]    short_delta,
	output logic signed [cdfb_pkg::LD_W-1:0]    long_delta,
	output logic signed [cdfb_pkg::AD_W-1:0]    accel_delta,
	output logic                                frame_done,
	output logic                                utterance_done,
	output logic                                too_short
);
	import cdfb_pkg::*;

	logic    run;
	logic    we;
	addr_t   waddr;
	sample_t wdata;
	addr_t   raddr_a;
	addr_t   raddr_b;
	sample_t rdata_a;
	sample_t rdata_b;
	issue_t  issue;

	assign cfg_ready = 1'b1;

	cdfb_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(DEPTH)
	) u_window (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (run),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	cdfb_decode u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.coef_value       (coef_value),
		.end_of_utterance (end_of_utterance),
		.cfg_valid        (cfg_valid),
		.cfg_data         (coef_count),
		.run              (run),
		.we               (we),
		.waddr            (waddr),
		.wdata            (wdata),
		.raddr_a          (raddr_a),
		.raddr_b          (raddr_b),
		.issue            (issue)
	);

	cdfb_calc u_calc (
		.clk            (clk),
		.arst_n         (arst_n),
		.issue          (issue),
		.rdata_a        (rdata_a),
		.rdata_b        (rdata_b),
		.run            (run),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_index    (frame_index),
		.coef_index     (coef_index),
		.cep_out        (cep_out),
		.short_delta    (short_delta),
		.long_delta     (long_delta),
		.accel_delta    (accel_delta),
		.frame_done     (frame_done),
		.utterance_done (utterance_done),
		.too_short      (too_short)
	);

endmodule

`default_nettype wire

// ===== bench/tb_cepstral_delta_feature_builder_top.sv =====
// Self-checking testbench for the cepstral delta feature builder top level.
`timescale 1ns / 100ps

module tb_cepstral_delta_feature_builder_top;
	import cdfb_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 30;
	localparam int OPEN_END      = 32'h7fffffff;
	localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7fff;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;

	typedef struct {
		logic [FRAME_W-1:0]       frame;
		logic [IDX_W-1:0]         coef;
		logic signed [COEF_W-1:0] cep;
		logic signed [SD_W-1:0]   sdelta;
		logic signed [LD_W-1:0]   ldelta;
		logic signed [AD_W-1:0]   adelta;
		logic                     fdone;
		logic                     udone;
		logic                     short_utt;
	} feature_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     command = CMD_DATA;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic                     end_of_utterance = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         coef_count = 5'd13;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [FRAME_W-1:0]       frame_index;
	logic [IDX_W-1:0]         coef_index;
	logic signed [COEF_W-1:0] cep_out;
	logic signed [SD_W-1:0]   short_delta;
	logic signed [LD_W-1:0]   long_delta;
	logic signed [AD_W-1:0]   accel_delta;
	logic                     frame_done;
	logic                     utterance_done;
	logic                     too_short;

	cepstral_delta_feature_builder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.coef_value(coef_value),
		.end_of_utterance(end_of_utterance),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.coef_count(coef_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_index(frame_index),
		.coef_index(coef_index),
		.cep_out(cep_out),
		.short_delta(short_delta),
		.long_delta(long_delta),
		.accel_delta(accel_delta),
		.frame_done(frame_done),
		.utterance_done(utterance_done),
		.too_short(too_short)
	);

	// feature predictor state
	logic signed [SAMPLE_WIDTH-1:0] hist [HISTORY_FRAMES][MAX_COEFS] = '{default: '0};
	logic [CFG_W-1:0] count_reg = 5'd13;
	int  rx_frames = 0;
	int  coef_pos = 0;
	int  tx_frames = 0;
	int  wr_slot = 0;
	int  back_left = 0;
	bit  draining = 1'b0;

	feature_t expected_features[$];
	feature_t head;
	int  mismatches = 0;
	int  taken_items = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	bit  idling = 1'b1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int coefs_per_frame();
		if (count_reg == 0)
			return 1;
		if (count_reg > MAX_COEFS)
			return MAX_COEFS;
		return int'(count_reg);
	endfunction

	function automatic int ring_slot(int base, int off);
		int o;
		o = off % HISTORY_FRAMES;
		if (o < 0)
			o += HISTORY_FRAMES;
		return (base + o) % HISTORY_FRAMES;
	endfunction

	function automatic int window_at(int tslot, int off, int pos);
		return int'(hist[ring_slot(tslot, off)][pos % MAX_COEFS]);
	endfunction

	// centre moved in so that a delta of reach x stays inside the utterance
	function automatic int clamp_shift(int t, int e, int x);
		if (t < x)
			return x - t;
		if (e < x)
			return e - x;
		return 0;
	endfunction

	function automatic feature_t build_feature(int tslot, int t, int e, bit short_utt, int pos,
			bit fdone, bit udone);
		feature_t f;
		int c;
		int sd;
		int ld;
		int ad;
		sd = 0;
		ld = 0;
		ad = 0;
		if (!short_utt) begin
			c = clamp_shift(t, e, SHORT_SPAN);
			sd = window_at(tslot, c + SHORT_SPAN, pos) - window_at(tslot, c - SHORT_SPAN, pos);
			c = clamp_shift(t, e, LONG_SPAN);
			ld = window_at(tslot, c + LONG_SPAN, pos) - window_at(tslot, c - LONG_SPAN, pos);
			c = clamp_shift(t, e, SHORT_SPAN + ACCEL_SPAN);
			ad = (window_at(tslot, c + ACCEL_SPAN + SHORT_SPAN, pos)
				- window_at(tslot, c + ACCEL_SPAN - SHORT_SPAN, pos))
				- (window_at(tslot, c - ACCEL_SPAN + SHORT_SPAN, pos)
				- window_at(tslot, c - ACCEL_SPAN - SHORT_SPAN, pos));
		end
		f.frame     = FRAME_W'(tx_frames);
		f.coef      = IDX_W'(pos);
		f.cep       = COEF_W'(window_at(tslot, 0, pos));
		f.sdelta    = SD_W'(sd);
		f.ldelta    = LD_W'(ld);
		f.adelta    = AD_W'(ad);
		f.fdone     = fdone;
		f.udone     = udone;
		f.short_utt = short_utt;
		return f;
	endfunction

	// advance the predictor by one accepted transaction
	task automatic predict_features(input logic cmd, input logic signed [COEF_W-1:0] val,
			input logic eou);
		bit last;
		bit made;
		int back;
		int t;
		last = (coef_pos + 1 >= coefs_per_frame());
		made = 1'b0;
		if (cmd == CMD_DATA) begin
			if (draining)
				return;
			taken_items++;
			hist[wr_slot][coef_pos % MAX_COEFS] = val;
			if (rx_frames >= LAG) begin
				expected_features.push_back(build_feature(ring_slot(wr_slot, -LAG),
					rx_frames - LAG, OPEN_END, 1'b0, coef_pos, last, 1'b0));
				made = 1'b1;
			end
			if (last) begin
				coef_pos = 0;
				if (rx_frames < 65535)
					rx_frames++;
				wr_slot = (wr_slot + 1) % HISTORY_FRAMES;
				if (made)
					tx_frames = (tx_frames + 1) & 16'hffff;
				if (eou) begin
					draining = 1'b1;
					back_left = (rx_frames >= MIN_FRAMES) ? LAG - 1 : rx_frames - 1;
				end
			end else begin
				coef_pos++;
			end
			return;
		end
		if (!draining)
			return;
		taken_items++;
		back = back_left;
		t = (rx_frames > back) ? rx_frames - 1 - back : 0;
		expected_features.push_back(build_feature(
			ring_slot(ring_slot(wr_slot, -1), -(back % HISTORY_FRAMES)), t, back,
			rx_frames < MIN_FRAMES, coef_pos, last, last && back == 0));
		if (last) begin
			coef_pos = 0;
			tx_frames = (tx_frames + 1) & 16'hffff;
			if (back == 0) begin
				draining = 1'b0;
				rx_frames = 0;
				tx_frames = 0;
				wr_slot = 0;
			end else begin
				back_left = back - 1;
			end
		end else begin
			coef_pos++;
		end
	endtask

	function automatic logic signed [COEF_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return COEF_MIN;
			1: return COEF_MAX;
			2: return COEF_W'($urandom_range(0, 15)) - COEF_W'(8);
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'($urandom_range(17, 31));
			2: return CFG_W'(MAX_COEFS);
			default: return CFG_W'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic send_item(input logic cmd, input logic signed [COEF_W-1:0] val,
			input logic eou);
		int gap;
		if (idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		coef_value <= val;
		end_of_utterance <= eou;
		do
			@(posedge clk);
		while (in_stall);
		predict_features(cmd, val, eou);
	endtask

	// wait for every pending result, then let in-flight ignored items retire
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_features.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] val);
		settle();
		cfg_valid <= 1'b1;
		coef_count <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		count_reg = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_utterance(input bit noisy);
		while (draining) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(CMD_DATA, rand_sample(), 1'($urandom_range(0, 1)));
			else
				send_item(CMD_FLUSH, rand_sample(), 1'($urandom_range(0, 1)));
		end
		if (noisy && $urandom_range(0, 3) == 0)
			send_item(CMD_FLUSH, rand_sample(), 1'($urandom_range(0, 1)));
	endtask

	task automatic run_utterance(input int frames, input bit noisy);
		int per_frame;
		bit eou;
		per_frame = coefs_per_frame();
		for (int f = 0; f < frames; f++) begin
			for (int p = 0; p < per_frame; p++) begin
				if (noisy && $urandom_range(0, 29) == 0)
					send_item(CMD_FLUSH, rand_sample(), 1'($urandom_range(0, 1)));
				if (f == frames - 1 && p == per_frame - 1)
					eou = 1'b1;
				else if (p != per_frame - 1)
					eou = noisy && $urandom_range(0, 15) == 0;
				else
					eou = noisy && $urandom_range(0, 60) == 0; // early end, rest is ignored
				send_item(CMD_DATA, rand_sample(), eou);
			end
		end
		drain_utterance(noisy);
	endtask

	task automatic test_reset_count();
		run_utterance(1, 1'b0);
	endtask

	task automatic test_full_window();
		write_count(5'd31);
		run_utterance(HISTORY_FRAMES, 1'b0);
	endtask

	task automatic test_delta_extremes();
		logic signed [COEF_W-1:0] rise [MIN_FRAMES];
		rise = '{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, 16'sh0000,
			COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX};
		write_count(5'd0);
		for (int pass = 0; pass < 2; pass++) begin
			for (int f = 0; f < MIN_FRAMES; f++)
				send_item(CMD_DATA, (pass == 0) ? rise[f] : ~rise[f], f == MIN_FRAMES - 1);
			drain_utterance(1'b0);
		end
		run_utterance(MIN_FRAMES - 1, 1'b0);
	endtask

	task automatic test_stray_items();
		write_count(5'd2);
		send_item(CMD_FLUSH, COEF_MAX, 1'b1);
		send_item(CMD_FLUSH, COEF_MIN, 1'b0);
		for (int f = 0; f < 10; f++) begin
			send_item(CMD_DATA, rand_sample(), f == 2);
			if (f == 4)
				send_item(CMD_FLUSH, rand_sample(), 1'b0);
			send_item(CMD_DATA, rand_sample(), f == 9);
		end
		send_item(CMD_FLUSH, rand_sample(), 1'b0);
		send_item(CMD_DATA, rand_sample(), 1'b1);
		drain_utterance(1'b0);
		send_item(CMD_FLUSH, rand_sample(), 1'b1);
	endtask

	task automatic test_count_change_mid_frame();
		write_count(5'd4);
		repeat (3) send_item(CMD_DATA, rand_sample(), 1'b0);
		write_count(5'd2);
		// position 3 is already past the new count, so this closes frame 0
		send_item(CMD_DATA, rand_sample(), 1'b0);
		run_utterance(MIN_FRAMES, 1'b0);
	endtask

	task automatic test_random_utterances(input int budget, input bit allow_idle);
		int start;
		int frames;
		start = taken_items;
		while (taken_items - start < budget) begin
			if ($urandom_range(0, 1))
				write_count(pick_count());
			idling = allow_idle && $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0, 1: frames = $urandom_range(1, MIN_FRAMES - 1);
				9: frames = $urandom_range(21, 32);
				default: frames = $urandom_range(MIN_FRAMES, 20);
			endcase
			run_utterance(frames, 1'b1);
		end
		settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling = 1'b1;
		test_reset_count();
		test_full_window();
		test_delta_extremes();
		test_stray_items();
		test_count_change_mid_frame();
		test_random_utterances(350, 1'b1);
		test_random_utterances(150, 1'b0);
		settle();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_features.size() == 0) begin
				$display("[%0t] result with none pending: frame %0d coef %0d",
					$time, frame_index, coef_index);
				mismatches++;
			end else begin
				head = expected_features.pop_front();
				check_field("frame_index", head.frame, frame_index);
				check_field("coef_index", head.coef, coef_index);
				check_field("cep_out", head.cep, cep_out);
				check_field("short_delta", head.sdelta, short_delta);
				check_field("long_delta", head.ldelta, long_delta);
				check_field("accel_delta", head.adelta, accel_delta);
				check_field("frame_done", head.fdone, frame_done);
				check_field("utterance_done", head.udone, utterance_done);
				check_field("too_short", head.short_utt, too_short);
			end
		end
	end

	// any handshake on any channel counts as progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] watchdog: %0d cycles without a transaction", $time, quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

endmodule

// ===== cepstral_delta_feature_builder_top.f =====
design/cdfb_pkg.sv
design/cdfb_ram.sv
design/cdfb_decode.sv
design/cdfb_calc.sv
design/cepstral_delta_feature_builder_top.sv
bench/tb_cepstral_delta_feature_builder_top.sv
